/* sv/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PATG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked also during reset
`define PATG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/patg_pkg.sv */
`timescale 1ns / 1ps
package patg_pkg;

  localparam int APPS        = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int NUM_REGS    = 4;
  localparam int CMDQ_DEPTH  = 2;

  localparam int OP_W      = 2;
  localparam int APP_ID_W  = 2;
  localparam int FIELD_TAG_W = 16;
  localparam int STATUS_W  = 3;
  localparam int LIMIT_W   = 16;
  localparam int REG_IDX_W = 2;

  localparam int APP_W   = (APPS > 1) ? $clog2(APPS) : 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = $clog2(APPS * QUEUE_DEPTH);
  localparam int QSTORE_DEPTH = APPS * QUEUE_DEPTH;

  localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RESET = LIMIT_W'(16);

  localparam logic [OP_W-1:0] OP_ARRIVE    = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLENISH = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PASSED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLENISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE        = 3'd4;

  typedef logic [APP_W-1:0]    app_idx_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [QPTR_W-1:0]   qptr_t;
  typedef logic [QCNT_W-1:0]   qcnt_t;
  typedef logic [QADDR_W-1:0]  qaddr_t;
  typedef logic [LIMIT_W-1:0]  token_t;

  typedef enum logic [2:0] {
    CMD_ARRIVE,
    CMD_REPLENISH,
    CMD_DISPATCH,
    CMD_NOP,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    app_idx_t  app;
    tag_t      tag;
  } cmd_t;

  typedef enum logic {
    BK_EXEC,
    BK_READ
  } back_state_t;

  function automatic qaddr_t queue_addr(app_idx_t app, qptr_t ptr);
    return QADDR_W'(int'(app) * QUEUE_DEPTH + int'(ptr));
  endfunction

  function automatic qptr_t ptr_inc(qptr_t ptr);
    return (int'(ptr) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(int'(ptr) + 1);
  endfunction

endpackage

/* sv/patg_if.sv */
`timescale 1ns / 1ps
interface patg_req_if import patg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [APP_ID_W-1:0]    app_id;
  logic [FIELD_TAG_W-1:0] packet_tag;

  modport source (output valid, op, app_id, packet_tag, input ready);
  modport sink (input valid, op, app_id, packet_tag, output ready);
endinterface

interface patg_rsp_if import patg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [APP_ID_W-1:0]    out_app;
  logic [FIELD_TAG_W-1:0] out_tag;

  modport source (output valid, status, out_app, out_tag, input ready);
  modport sink (input valid, status, out_app, out_tag, output ready);
endinterface

/* sv/patg_ram.sv */
`timescale 1ns / 1ps
module patg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/patg_front.sv */
`timescale 1ns / 1ps
module patg_front import patg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  patg_req_if.sink    req,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       entries [CMDQ_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       classified;
  logic       push;

  // classify the incoming transaction
  always_comb begin
    classified.app = APP_W'(req.app_id);
    classified.tag = TAG_BITS'(req.packet_tag);
    case (req.op)
      OP_ARRIVE: begin
        if (int'(req.app_id) >= APPS) begin
          classified.kind = CMD_DROP;
        end else begin
          classified.kind = CMD_ARRIVE;
        end
      end
      OP_REPLENISH: classified.kind = CMD_REPLENISH;
      OP_DISPATCH:  classified.kind = CMD_DISPATCH;
      default:      classified.kind = CMD_NOP;
    endcase
  end

  assign req.ready = (int'(count) != CMDQ_DEPTH);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!push && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* sv/patg_back.sv */
`timescale 1ns / 1ps
module patg_back import patg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  patg_rsp_if.source           rsp
);

  back_state_t state, state_next;
  token_t      limits [NUM_REGS];
  token_t      tokens [APPS];
  token_t      tokens_next [APPS];
  qptr_t       head [APPS];
  qptr_t       head_next [APPS];
  qptr_t       tail [APPS];
  qptr_t       tail_next [APPS];
  qcnt_t       qcount [APPS];
  qcnt_t       qcount_next [APPS];
  app_idx_t    rd_app, rd_app_next;

  logic                   rsp_valid, rsp_valid_next;
  logic [STATUS_W-1:0]    rsp_status, rsp_status_next;
  logic [APP_ID_W-1:0]    rsp_app, rsp_app_next;
  logic [FIELD_TAG_W-1:0] rsp_tag, rsp_tag_next;

  logic     out_free;
  logic     ram_wr_en;
  qaddr_t   ram_wr_addr;
  logic     ram_rd_en;
  qaddr_t   ram_rd_addr;
  tag_t     ram_rd_data;
  logic     found;
  app_idx_t sel;

  assign out_free   = !rsp_valid || rsp.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.out_app = rsp_app;
  assign rsp.out_tag = rsp_tag;

  patg_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QSTORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (cmd.tag),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // first application in index order with a waiting request and a token
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = APPS - 1; i >= 0; i--) begin
      if (qcount[i] != '0 && tokens[i] != '0) begin
        found = 1'b1;
        sel   = APP_W'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    tokens_next     = tokens;
    head_next       = head;
    tail_next       = tail;
    qcount_next     = qcount;
    rd_app_next     = rd_app;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_app_next    = rsp_app;
    rsp_tag_next    = rsp_tag;
    cmd_pop         = 1'b0;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = queue_addr(cmd.app, tail[cmd.app]);
    ram_rd_en       = 1'b0;
    ram_rd_addr     = queue_addr(sel, head[sel]);
    case (state)
      BK_EXEC: begin
        if (cmd_valid && out_free) begin
          cmd_pop         = 1'b1;
          rsp_valid_next  = 1'b1;
          rsp_app_next    = '0;
          rsp_tag_next    = '0;
          case (cmd.kind)
            CMD_ARRIVE: begin
              if (tokens[cmd.app] != '0) begin
                tokens_next[cmd.app] = tokens[cmd.app] - token_t'(1);
                rsp_status_next      = ST_PASSED;
                rsp_app_next         = APP_ID_W'(cmd.app);
                rsp_tag_next         = FIELD_TAG_W'(cmd.tag);
              end else if (int'(qcount[cmd.app]) == QUEUE_DEPTH) begin
                rsp_status_next = ST_DROPPED;
              end else begin
                ram_wr_en            = 1'b1;
                tail_next[cmd.app]   = ptr_inc(tail[cmd.app]);
                qcount_next[cmd.app] = qcount[cmd.app] + qcnt_t'(1);
                rsp_status_next      = ST_QUEUED;
              end
            end
            CMD_REPLENISH: begin
              for (int i = 0; i < APPS; i++) begin
                tokens_next[i] = limits[i % NUM_REGS];
              end
              rsp_status_next = ST_REPLENISHED;
            end
            CMD_DISPATCH: begin
              if (found) begin
                ram_rd_en        = 1'b1;
                tokens_next[sel] = tokens[sel] - token_t'(1);
                head_next[sel]   = ptr_inc(head[sel]);
                qcount_next[sel] = qcount[sel] - qcnt_t'(1);
                rd_app_next      = sel;
                rsp_valid_next   = 1'b0;
                state_next       = BK_READ;
              end else begin
                rsp_status_next = ST_NONE;
              end
            end
            CMD_DROP: rsp_status_next = ST_DROPPED;
            default:  rsp_status_next = ST_NONE;
          endcase
        end
      end
      BK_READ: begin
        // output slot was emptied when the dispatch was taken
        rsp_valid_next  = 1'b1;
        rsp_status_next = ST_PASSED;
        rsp_app_next    = APP_ID_W'(rd_app);
        rsp_tag_next    = FIELD_TAG_W'(ram_rd_data);
        state_next      = BK_EXEC;
      end
      default: state_next = BK_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_EXEC;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        limits[i] <= TOKEN_LIMIT_RESET;
      end
      for (int i = 0; i < APPS; i++) begin
        tokens[i] <= TOKEN_LIMIT_RESET;
        head[i]   <= '0;
        tail[i]   <= '0;
        qcount[i] <= '0;
      end
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      tokens    <= tokens_next;
      head      <= head_next;
      tail      <= tail_next;
      qcount    <= qcount_next;
      if (cfg_wr_en && int'(cfg_index) < NUM_REGS) begin
        limits[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_app     <= rd_app_next;
    rsp_status <= rsp_status_next;
    rsp_app    <= rsp_app_next;
    rsp_tag    <= rsp_tag_next;
  end

endmodule

/* sv/per_app_token_gate_with_queues.sv */
// result registered when the accepted request executes from the command queue;
//   a dispatch that releases a queued request first reads the queue RAM in BK_READ
// one item per cycle unless the response side stalls; no command is taken in BK_READ
// a 2-entry command queue decouples the request side from execution
// reset: token counters and limits to 16, queue pointers and counts to zero;
//   queue RAM is not cleared, no clearing pass
`timescale 1ns / 1ps
module per_app_token_gate_with_queues import patg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  patg_req_if.sink             req,
  patg_rsp_if.source           rsp,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  patg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  patg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

/* sv/patg_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module patg_checker import patg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    rsp_status,
  input logic [APP_ID_W-1:0]    rsp_app,
  input logic [FIELD_TAG_W-1:0] rsp_tag
);

  logic [3:0] outstanding;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // transactions accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 4'd0;
    end else if (req_acc && !rsp_acc) begin
      outstanding <= outstanding + 4'd1;
    end else if (!req_acc && rsp_acc) begin
      outstanding <= outstanding - 4'd1;
    end
  end

  `PATG_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !rsp_valid, "response valid after reset")
  `PATG_ASSERT(a_rsp_has_request, clk, rst, rsp_valid |-> outstanding != 4'd0, "response without request")
  `PATG_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag), "stalled response changed")
  `PATG_ASSERT(a_zero_fields, clk, rst, rsp_valid && rsp_status != ST_PASSED |-> rsp_app == '0 && rsp_tag == '0, "release fields set without release")

endmodule

bind per_app_token_gate_with_queues patg_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_app    (rsp.out_app),
  .rsp_tag    (rsp.out_tag)
);

/* tb/token_gate_checker.sv */
`timescale 1ns / 1ps
module token_gate_checker import patg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  patg_req_if                  req,
  patg_rsp_if                  rsp,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   checked
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [APP_ID_W-1:0]    app;
    logic [FIELD_TAG_W-1:0] tag;
  } outcome_t;

  token_t   limit_reg [NUM_REGS];
  token_t   tokens [APPS];
  tag_t     held [APPS][QUEUE_DEPTH];
  int       head [APPS];
  int       fill [APPS];
  outcome_t due_outcomes [$];
  outcome_t seen, want;
  int       n_bad, n_checked, i;

  function automatic outcome_t gate_outcome(logic [OP_W-1:0] op, logic [APP_ID_W-1:0] app,
                                            logic [FIELD_TAG_W-1:0] tag);
    outcome_t o;
    int       a;
    bit       done;
    o = '0;
    o.status = ST_NONE;
    done = 1'b0;
    if (op == OP_ARRIVE) begin
      if (int'(app) >= APPS) begin
        o.status = ST_DROPPED;
      end else if (tokens[app] != 0) begin
        tokens[app]--;
        o.status = ST_PASSED;
        o.app = app;
        o.tag = tag_t'(tag);
      end else if (fill[app] >= QUEUE_DEPTH) begin
        o.status = ST_DROPPED;
      end else begin
        held[app][(head[app] + fill[app]) % QUEUE_DEPTH] = tag_t'(tag);
        fill[app]++;
        o.status = ST_QUEUED;
      end
    end else if (op == OP_REPLENISH) begin
      for (a = 0; a < APPS; a++) tokens[a] = limit_reg[a % NUM_REGS];
      o.status = ST_REPLENISHED;
    end else if (op == OP_DISPATCH) begin
      for (a = 0; a < APPS; a++) begin
        if (!done && fill[a] > 0 && tokens[a] != 0) begin
          done = 1'b1;
          tokens[a]--;
          o.status = ST_PASSED;
          o.app = APP_ID_W'(a);
          o.tag = held[a][head[a]];
          head[a] = (head[a] + 1) % QUEUE_DEPTH;
          fill[a]--;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < NUM_REGS; i++) limit_reg[i] = TOKEN_LIMIT_RESET;
      for (i = 0; i < APPS; i++) begin
        tokens[i] = TOKEN_LIMIT_RESET;
        head[i] = 0;
        fill[i] = 0;
      end
      due_outcomes.delete();
      n_bad = 0;
      n_checked = 0;
      mismatches <= 0;
      outstanding <= 0;
      checked <= 0;
    end else begin
      if (cfg_wr_en && int'(cfg_index) < NUM_REGS) limit_reg[cfg_index] = cfg_data;
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.app = rsp.out_app;
        seen.tag = rsp.out_tag;
        n_checked++;
        if (due_outcomes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected response at %0t: status %0d app %0d tag %h",
                     $time, seen.status, seen.app, seen.tag);
        end else begin
          want = due_outcomes[0];
          due_outcomes.delete(0);
          if (seen.status !== want.status || seen.app !== want.app ||
              seen.tag !== want.tag) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch at %0t: want status %0d app %0d tag %h, got %0d %0d %h",
                       $time, want.status, want.app, want.tag,
                       seen.status, seen.app, seen.tag);
          end
        end
      end
      // transaction accepted on the request side
      if (req.valid && req.ready)
        due_outcomes = {due_outcomes, gate_outcome(req.op, req.app_id, req.packet_tag)};
      mismatches <= n_bad;
      outstanding <= due_outcomes.size();
      checked <= n_checked;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import patg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 95;
  localparam int LONG_HOLD = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;

  int mismatches, outstanding, checked;
  int tx_run = 0;
  int hold_asked = 0;
  int n_settings = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  patg_req_if req_ch ();
  patg_rsp_if rsp_ch ();

  per_app_token_gate_with_queues dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  token_gate_checker gate_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic token_t pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return token_t'($urandom_range(1, 4));
    if (r < 9) return token_t'($urandom_range(5, 24));
    return token_t'($urandom_range(0, 65535));
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [APP_ID_W-1:0] app,
                      input logic [FIELD_TAG_W-1:0] tag);
    int gap;
    gap = draw_wait(tx_run);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.app_id <= app;
    req_ch.packet_tag <= tag;
    do @(posedge clk); while (!req_ch.ready);
    op_seen[op]++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input token_t lim [NUM_REGS]);
    int k;
    for (k = 0; k < NUM_REGS; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_IDX_W'(k);
      cfg_data <= lim[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // response side
  initial begin
    int stall;
    int rx_run;
    int hold_taken;
    rx_run = 0;
    hold_taken = 0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_asked != hold_taken) begin
        stall = LONG_HOLD;
        hold_taken = hold_asked;
      end else begin
        stall = draw_wait(rx_run);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    token_t          lim [NUM_REGS];
    int              ph, n, r, arrive_pct, repl_pct;
    logic [OP_W-1:0] op;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ARRIVE;
    req_ch.app_id = '0;
    req_ch.packet_tag = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // new limits wait for the next replenish
    lim = '{16'd0, 16'd1, 16'hFFFF, 16'd2};
    set_limits(lim);
    send(OP_ARRIVE, 2'd0, 16'hFFFF);
    send(OP_UNUSED, 2'd3, 16'hFFFF);
    send(OP_REPLENISH, 2'd0, 16'h0000);
    // zero limit: fill the queue, then one more is dropped
    for (n = 0; n < QUEUE_DEPTH; n++) send(OP_ARRIVE, 2'd0, FIELD_TAG_W'(n * 16'h1111));
    send(OP_ARRIVE, 2'd0, 16'hAAAA);
    send(OP_DISPATCH, 2'd1, 16'h5555);
    send(OP_ARRIVE, 2'd1, 16'h8001);
    send(OP_ARRIVE, 2'd1, 16'h7FFE);
    send(OP_ARRIVE, 2'd3, 16'h0000);
    send(OP_DISPATCH, 2'd2, 16'h5555);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      for (n = 0; n < NUM_REGS; n++) begin
        if (ph == 0) lim[n] = '0;
        else if (ph == 1) lim[n] = '1;
        else lim[n] = pick_limit();
      end
      set_limits(lim);
      if (ph == 1) hold_asked++;
      arrive_pct = $urandom_range(40, 75);
      repl_pct = $urandom_range(3, 15);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < arrive_pct) op = OP_ARRIVE;
        else if (r < arrive_pct + repl_pct) op = OP_REPLENISH;
        else if (r < 96) op = OP_DISPATCH;
        else op = OP_UNUSED;
        send(op, APP_ID_W'($urandom_range(0, 3)), FIELD_TAG_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 149) == 0) drain();
      end
    end
    drain();

    $display("run covered %0d arrivals, %0d replenishes, %0d dispatches, %0d unused ops",
             op_seen[OP_ARRIVE], op_seen[OP_REPLENISH], op_seen[OP_DISPATCH],
             op_seen[OP_UNUSED]);
    $display("%0d responses checked over %0d limit settings, %0d mismatches",
             checked, n_settings, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d responses still due", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/patg_pkg.sv
sv/patg_if.sv
sv/patg_ram.sv
sv/patg_front.sv
sv/patg_back.sv
sv/per_app_token_gate_with_queues.sv
sv/patg_checker.sv
tb/token_gate_checker.sv
tb/tb_top.sv
